### rtl/i2cbm_pkg.sv
// Shared types, constants and a helper function for the I2C bit-level master.
`timescale 1ns / 1ps
package i2cbm_pkg;

  localparam int DATA_BITS = 8;
  localparam int PHASE_W   = 5;
  localparam int TICK_W    = 10;
  localparam int APB_AW    = 2;
  localparam int APB_DW    = 32;

  localparam logic [TICK_W-1:0] TPP_RESET = TICK_W'(10);

  // Register addresses on the APB port
  localparam logic [APB_AW-1:0] REG_TICKS_PER_PHASE = APB_AW'(0);

  // Request codes; the tick code also marks the idle engine
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_START    = 3'd1,
    ACT_STOP     = 3'd2,
    ACT_WRITE    = 3'd3,
    ACT_READ     = 3'd4,
    ACT_SEND_ACK = 3'd5,
    ACT_RECV_ACK = 3'd6
  } action_t;

  localparam action_t CMD_IDLE = ACT_TICK;

  // Result of one request, as loaded into the output register
  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 ack_received;
    logic                 rejected;
  } result_t;

  // Number of timed phases in each command sequence
  function automatic logic [PHASE_W-1:0] seq_length(input action_t cmd);
    logic [PHASE_W-1:0] len;
    unique case (cmd)
      ACT_START:    len = PHASE_W'(4);
      ACT_STOP:     len = PHASE_W'(3);
      ACT_WRITE:    len = PHASE_W'(3 * DATA_BITS);
      ACT_READ:     len = PHASE_W'(1 + 2 * DATA_BITS);
      ACT_SEND_ACK: len = PHASE_W'(3);
      ACT_RECV_ACK: len = PHASE_W'(3);
      default:      len = '0;
    endcase
    return len;
  endfunction

endpackage

### rtl/i2cbm_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface i2cbm_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       ack_to_send;
  logic       sda_in;

  modport source (output valid, action, tx_byte, ack_to_send, sda_in, input ready);
  modport sink   (input valid, action, tx_byte, ack_to_send, sda_in, output ready);
endinterface

interface i2cbm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_received, rejected, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
                  ack_received, rejected, output ready);
endinterface

### rtl/i2cbm_cfg.sv
// APB configuration register block holding ticks_per_phase.
`timescale 1ns / 1ps
module i2cbm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbm_pkg::APB_AW-1:0]  paddr,
  input  logic [i2cbm_pkg::APB_DW-1:0]  pwdata,
  output logic [i2cbm_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output logic [i2cbm_pkg::TICK_W-1:0]  ticks_per_phase
);
  import i2cbm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_TICKS_PER_PHASE);

  // Write the phase length register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= TPP_RESET;
    end else if (wr_en) begin
      ticks_per_phase <= pwdata[TICK_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_TICKS_PER_PHASE) begin
      prdata = {{(APB_DW-TICK_W){1'b0}}, ticks_per_phase};
    end
  end

endmodule

### rtl/i2cbm_engine.sv
// Bit engine: command state, phase timing, pin drive and shift register.
`timescale 1ns / 1ps
module i2cbm_engine (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [2:0]                       action,
  input  logic [i2cbm_pkg::DATA_BITS-1:0]  tx_byte,
  input  logic                             ack_to_send,
  input  logic                             sda_in,
  input  logic [i2cbm_pkg::TICK_W-1:0]     ticks_per_phase,
  output i2cbm_pkg::result_t               result
);
  import i2cbm_pkg::*;

  action_t                current_command, current_command_next;
  logic [PHASE_W-1:0]     phase_index, phase_index_next;
  logic [1:0]             bit_step, bit_step_next;   // phase index mod 3
  logic [TICK_W-1:0]      tick_count, tick_count_next;
  logic [DATA_BITS-1:0]   shift_reg, shift_reg_next;
  logic                   scl_out, scl_out_next;
  logic                   sda_out, sda_out_next;
  logic                   ack_latch, ack_latch_next;
  logic [DATA_BITS-1:0]   rx_hold, rx_hold_next;

  // Hold state between requests; update only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      current_command <= CMD_IDLE;
      phase_index     <= '0;
      bit_step        <= '0;
      tick_count      <= '0;
      shift_reg       <= '0;
      scl_out         <= 1'b1;
      sda_out         <= 1'b1;
      ack_latch       <= 1'b1;
      rx_hold         <= '0;
    end else if (accept) begin
      current_command <= current_command_next;
      phase_index     <= phase_index_next;
      bit_step        <= bit_step_next;
      tick_count      <= tick_count_next;
      shift_reg       <= shift_reg_next;
      scl_out         <= scl_out_next;
      sda_out         <= sda_out_next;
      ack_latch       <= ack_latch_next;
      rx_hold         <= rx_hold_next;
    end
  end

  // Next state and result for one request
  always_comb begin
    action_t              act;
    logic                 busy;
    logic                 phase_end;
    logic [PHASE_W-1:0]   phase_inc;
    logic [1:0]           step_inc;
    logic                 done;
    logic                 rej;

    act       = action_t'(action);
    busy      = (current_command != CMD_IDLE);
    phase_end = ({1'b0, tick_count} + (TICK_W+1)'(1)) >= {1'b0, ticks_per_phase};
    phase_inc = phase_index + PHASE_W'(1);
    step_inc  = (bit_step == 2'd2) ? 2'd0 : bit_step + 2'd1;
    done      = 1'b0;
    rej       = 1'b0;

    current_command_next = current_command;
    phase_index_next     = phase_index;
    bit_step_next        = bit_step;
    tick_count_next      = tick_count;
    shift_reg_next       = shift_reg;
    scl_out_next         = scl_out;
    sda_out_next         = sda_out;
    ack_latch_next       = ack_latch;
    rx_hold_next         = rx_hold;

    unique case (act)
      ACT_START, ACT_STOP, ACT_WRITE, ACT_READ, ACT_SEND_ACK, ACT_RECV_ACK: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          // Start the command and drive its first pin level
          current_command_next = act;
          phase_index_next     = '0;
          bit_step_next        = '0;
          tick_count_next      = '0;
          shift_reg_next       = '0;
          unique case (act)
            ACT_STOP:     sda_out_next = 1'b0;
            ACT_SEND_ACK: sda_out_next = ack_to_send;
            ACT_WRITE: begin
              sda_out_next   = tx_byte[DATA_BITS-1];
              shift_reg_next = {tx_byte[DATA_BITS-2:0], 1'b0};
            end
            default:      sda_out_next = 1'b1;
          endcase
        end
      end
      ACT_TICK: begin
        if (busy) begin
          if (phase_end) begin
            // Close the phase: sample SDA where SCL was high
            if (current_command == ACT_READ && phase_index[0]) begin
              shift_reg_next = {shift_reg[DATA_BITS-2:0], sda_in};
            end else if (current_command == ACT_RECV_ACK && phase_index == PHASE_W'(1)) begin
              ack_latch_next = sda_in;
            end
            tick_count_next = '0;
            bit_step_next   = step_inc;
            if (phase_inc >= seq_length(current_command)) begin
              // Sequence finished
              if (current_command == ACT_READ) begin
                rx_hold_next = shift_reg_next;
              end
              current_command_next = CMD_IDLE;
              phase_index_next     = '0;
              done                 = 1'b1;
            end else begin
              // Advance to the next phase and drive its pin level
              phase_index_next = phase_inc;
              unique case (current_command)
                ACT_START: begin
                  if (phase_inc == PHASE_W'(1)) scl_out_next = 1'b1;
                  else if (phase_inc == PHASE_W'(2)) sda_out_next = 1'b0;
                  else scl_out_next = 1'b0;
                end
                ACT_STOP: begin
                  if (phase_inc == PHASE_W'(1)) scl_out_next = 1'b1;
                  else sda_out_next = 1'b1;
                end
                ACT_WRITE: begin
                  if (step_inc == 2'd0) begin
                    sda_out_next   = shift_reg[DATA_BITS-1];
                    shift_reg_next = {shift_reg[DATA_BITS-2:0], 1'b0};
                  end else if (step_inc == 2'd1) begin
                    scl_out_next = 1'b1;
                  end else begin
                    scl_out_next = 1'b0;
                  end
                end
                ACT_READ: scl_out_next = phase_inc[0];
                ACT_SEND_ACK, ACT_RECV_ACK: scl_out_next = (phase_inc == PHASE_W'(1));
                default: ;
              endcase
            end
          end else begin
            tick_count_next = tick_count + TICK_W'(1);
          end
        end
      end
      default: ;  // unused code: no effect
    endcase

    result.scl_level    = scl_out_next;
    result.sda_level    = sda_out_next;
    result.busy_res     = (current_command_next != CMD_IDLE);
    result.done_res     = done;
    result.rx_byte      = rx_hold_next;
    result.ack_received = ack_latch_next;
    result.rejected     = rej;
  end

endmodule

### rtl/i2c_bit_level_master.sv
// Top level of the I2C bit-level master: channels, config port, output register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  cmd     | in  | valid/ready   | action, tx_byte, ack_to_send, sda_in
//  res     | out | valid/ready   | scl_level, sda_level, busy_res, done_res,
//          |     |               | rx_byte, ack_received, rejected
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (ticks_per_phase)
//
// One request per clock while cmd.ready is high; each result is loaded into the
// output register, which is the only stage, and appears in the cycle after its request.
// cmd.ready is high whenever the output register is empty or being drained,
// so a stalled result blocks new requests only while it is not taken.
// Synchronous reset releases both pins and sets ticks_per_phase to 10.
`timescale 1ns / 1ps
module i2c_bit_level_master (
  input  logic                          clk,
  input  logic                          rst,
  i2cbm_cmd_if.sink                     cmd,
  i2cbm_res_if.source                   res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [i2cbm_pkg::APB_AW-1:0]  paddr,
  input  logic [i2cbm_pkg::APB_DW-1:0]  pwdata,
  output logic [i2cbm_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import i2cbm_pkg::*;

  logic [TICK_W-1:0] ticks_per_phase;
  logic              accept;
  logic              out_valid;
  result_t           result;
  result_t           out_data;

  i2cbm_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .ticks_per_phase (ticks_per_phase)
  );

  assign cmd.ready = !out_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  i2cbm_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .action          (cmd.action),
    .tx_byte         (cmd.tx_byte),
    .ack_to_send     (cmd.ack_to_send),
    .sda_in          (cmd.sda_in),
    .ticks_per_phase (ticks_per_phase),
    .result          (result)
  );

  // Load the result on each request, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  assign res.valid        = out_valid;
  assign res.scl_level    = out_data.scl_level;
  assign res.sda_level    = out_data.sda_level;
  assign res.busy_res     = out_data.busy_res;
  assign res.done_res     = out_data.done_res;
  assign res.rx_byte      = out_data.rx_byte;
  assign res.ack_received = out_data.ack_received;
  assign res.rejected     = out_data.rejected;

endmodule
